// ===== hw/rtl/rfid_frame_double_read_check_unit_defines.svh =====
// Assertion macros for the RTL of the double-read check block.
`ifndef RFID_FRAME_DOUBLE_READ_CHECK_UNIT_DEFINES_SVH
`define RFID_FRAME_DOUBLE_READ_CHECK_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RFDRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define RFDRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/rfdrc_pkg.sv =====
package rfdrc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE     = 2'd2;

  // Register reset values
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd200;
  localparam logic [7:0] START_CODE_RST    = 8'h0A;
  localparam logic [7:0] STOP_CODE_RST     = 8'h0D;

  // Tick counter saturates here and fails the read
  localparam logic [7:0] WAIT_MAX = 8'hFF;

  // Frame protocol phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CAPTURE = 3'd1,
    PH_DROP    = 3'd2,
    PH_START   = 3'd3,
    PH_COMPARE = 3'd4
  } frame_phase_t;

  // Sequencer state for one item
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_STEP1,
    SQ_STEP2,
    SQ_EMIT,
    SQ_FAIL
  } seq_state_t;

  // Shared comparator result
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

  // Tag store command
  typedef struct packed {
    logic wr;
    logic clr;
  } store_cmd_t;

endpackage

// ===== hw/rtl/rfdrc_cmp.sv =====
// Shared 8-bit comparator: equality and unsigned greater-than.
module rfdrc_cmp (
  input  logic [7:0]          a,
  input  logic [7:0]          b,
  output rfdrc_pkg::cmp_res_t res
);

  assign res.eq = (a == b);
  assign res.gt = (a > b);

endmodule

// ===== hw/rtl/rfdrc_store.sv =====
// Tag byte store with per-entry valid bits; an invalid entry reads as zero.
module rfdrc_store #(
  parameter int TAG_BYTES = 10,
  parameter int CW        = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rfdrc_pkg::store_cmd_t cmd,
  input  logic [CW-1:0]         addr,
  input  logic [7:0]            wr_data,
  output logic [7:0]            rd_data
);

  logic [7:0]           mem [TAG_BYTES];
  logic [TAG_BYTES-1:0] valid;

  // valid bits: reset and clear wipe the whole store at once
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      valid <= '0;
    end else if (cmd.wr) begin
      valid[addr] <= 1'b1;
    end
  end

  // data entries
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wr_data;
    end
  end

  assign rd_data = valid[addr] ? mem[addr] : 8'h00;

endmodule

// ===== hw/rtl/rfid_frame_double_read_check_unit.sv =====
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata[7:0] rx_byte; tuser req_type (0 byte, 1 tick)
// m_axis   | out | tdata[7:0] tag_byte, [11:8] tag_index; tuser tag_ok; tlast last_of_run
// cfg      | in  | cfg_index register (0 timeout, 1 start, 2 stop); cfg_data value
//
// An item is accepted, then makes one pass through the shared comparator.
// A repeat-frame byte gets a stop check, then a compare against the stored byte.
// A failure then emits its single beat; a confirmed read emits one beat per tag byte.
// Input is held off while an item is in the sequencer or a result burst runs.
// A stalled m_axis holds the sequencer in its emit or fail step. cfg is always ready.
// Reset is synchronous; the tag store is cleared through its valid bits.
`include "rfid_frame_double_read_check_unit_defines.svh"

module rfid_frame_double_read_check_unit #(
  parameter int TAG_BYTES = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
  input  logic                            s_axis_tuser,   // [0] req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [7:0] tag_byte, [11:8] tag_index
  output logic                            m_axis_tuser,   // [0] tag_ok
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rfdrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  localparam int CW = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(TAG_BYTES - 1);

  // configuration registers
  logic [7:0] timeout_ticks;
  logic [7:0] start_code;
  logic [7:0] stop_code;

  // protocol state
  rfdrc_pkg::frame_phase_t phase, phase_next;
  rfdrc_pkg::seq_state_t   seq, seq_next;
  logic [CW-1:0]           count, count_next;
  logic [7:0]              wait_ticks, wait_next;

  // latched item
  logic       item_tick;
  logic [7:0] item_byte;

  // shared comparator
  logic [7:0]          cmp_a, cmp_b;
  rfdrc_pkg::cmp_res_t cmp_res;

  // store
  rfdrc_pkg::store_cmd_t st_cmd;
  logic [7:0]            rd_data;

  // output register
  logic        out_valid;
  logic        out_ok;
  logic [7:0]  out_byte;
  logic [3:0]  out_index;
  logic        out_last;
  logic        push, push_ok, push_last;
  logic [7:0]  push_byte;
  logic        slot_free;
  logic        in_fire;
  logic        last_idx;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (seq == rfdrc_pkg::SQ_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid || m_axis_tready;
  assign last_idx      = (count == LAST_IDX);

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= rfdrc_pkg::TIMEOUT_TICKS_RST;
      start_code    <= rfdrc_pkg::START_CODE_RST;
      stop_code     <= rfdrc_pkg::STOP_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rfdrc_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        rfdrc_pkg::REG_START_CODE:    start_code    <= cfg_data;
        rfdrc_pkg::REG_STOP_CODE:     stop_code     <= cfg_data;
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_tick <= s_axis_tuser;
      item_byte <= s_axis_tdata;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= rfdrc_pkg::SQ_IDLE;
      phase      <= rfdrc_pkg::PH_HUNT;
      count      <= '0;
      wait_ticks <= '0;
    end else begin
      seq        <= seq_next;
      phase      <= phase_next;
      count      <= count_next;
      wait_ticks <= wait_next;
    end
  end

  // comparator operands for the current step
  always_comb begin
    cmp_a = item_byte;
    cmp_b = start_code;
    case (seq)
      rfdrc_pkg::SQ_STEP1: begin
        if (item_tick) begin
          cmp_a = wait_ticks;
          cmp_b = timeout_ticks;
        end else if (phase inside {rfdrc_pkg::PH_CAPTURE, rfdrc_pkg::PH_COMPARE}) begin
          cmp_b = stop_code;
        end
      end
      rfdrc_pkg::SQ_STEP2: begin
        cmp_b = rd_data;
      end
      default: ;
    endcase
  end

  // sequencer: one comparator pass per step
  always_comb begin
    seq_next   = seq;
    phase_next = phase;
    count_next = count;
    wait_next  = wait_ticks;
    st_cmd     = '0;
    push       = 1'b0;
    push_ok    = 1'b0;
    push_byte  = 8'h00;
    push_last  = 1'b0;
    case (seq)
      rfdrc_pkg::SQ_IDLE: begin
        if (in_fire) seq_next = rfdrc_pkg::SQ_STEP1;
      end
      rfdrc_pkg::SQ_STEP1: begin
        seq_next = rfdrc_pkg::SQ_IDLE;
        if (item_tick) begin
          // ticks only count while waiting for the repeat frame
          if (phase inside {rfdrc_pkg::PH_DROP, rfdrc_pkg::PH_START}) begin
            if (cmp_res.gt || (wait_ticks == rfdrc_pkg::WAIT_MAX)) begin
              seq_next = rfdrc_pkg::SQ_FAIL;
            end else begin
              wait_next = wait_ticks + 8'd1;
            end
          end
        end else begin
          case (phase)
            rfdrc_pkg::PH_CAPTURE: begin
              if (cmp_res.eq) begin
                phase_next = rfdrc_pkg::PH_DROP;
                count_next = '0;
                wait_next  = '0;
              end else begin
                st_cmd.wr = 1'b1;
                if (last_idx) begin
                  phase_next = rfdrc_pkg::PH_DROP;
                  count_next = '0;
                  wait_next  = '0;
                end else begin
                  count_next = count + CW'(1);
                end
              end
            end
            rfdrc_pkg::PH_DROP: begin
              phase_next = rfdrc_pkg::PH_START;
            end
            rfdrc_pkg::PH_START: begin
              if (!cmp_res.eq) begin
                seq_next = rfdrc_pkg::SQ_FAIL;
              end else begin
                count_next = '0;
                phase_next = rfdrc_pkg::PH_COMPARE;
              end
            end
            rfdrc_pkg::PH_COMPARE: begin
              // stop byte ends a short repeat frame as a match
              if (cmp_res.eq) begin
                count_next = '0;
                seq_next   = rfdrc_pkg::SQ_EMIT;
              end else begin
                seq_next = rfdrc_pkg::SQ_STEP2;
              end
            end
            default: begin
              phase_next = rfdrc_pkg::PH_HUNT;
              if (cmp_res.eq) begin
                count_next = '0;
                phase_next = rfdrc_pkg::PH_CAPTURE;
              end
            end
          endcase
        end
      end
      rfdrc_pkg::SQ_STEP2: begin
        // repeat byte against stored byte
        if (!cmp_res.eq) begin
          seq_next = rfdrc_pkg::SQ_FAIL;
        end else if (last_idx) begin
          count_next = '0;
          seq_next   = rfdrc_pkg::SQ_EMIT;
        end else begin
          count_next = count + CW'(1);
          seq_next   = rfdrc_pkg::SQ_IDLE;
        end
      end
      rfdrc_pkg::SQ_EMIT: begin
        // count walks the store as the emit index
        if (slot_free) begin
          push      = 1'b1;
          push_ok   = 1'b1;
          push_byte = rd_data;
          push_last = last_idx;
          if (last_idx) begin
            phase_next = rfdrc_pkg::PH_HUNT;
            count_next = '0;
            wait_next  = '0;
            seq_next   = rfdrc_pkg::SQ_IDLE;
          end else begin
            count_next = count + CW'(1);
          end
        end
      end
      rfdrc_pkg::SQ_FAIL: begin
        if (slot_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          st_cmd.clr = 1'b1;
          phase_next = rfdrc_pkg::PH_HUNT;
          count_next = '0;
          wait_next  = '0;
          seq_next   = rfdrc_pkg::SQ_IDLE;
        end
      end
      default: begin
        seq_next = rfdrc_pkg::SQ_IDLE;
      end
    endcase
  end

  rfdrc_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  rfdrc_store #(
    .TAG_BYTES (TAG_BYTES),
    .CW        (CW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (st_cmd),
    .addr    (count),
    .wr_data (item_byte),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_ok    <= push_ok;
      out_byte  <= push_byte;
      out_index <= push_ok ? 4'(count) : 4'd0;
      out_last  <= push_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_index, out_byte};
  assign m_axis_tuser  = out_ok;
  assign m_axis_tlast  = out_last;

  // checks
  `RFDRC_ASSERT(a_wait_idle_zero,
    (phase == rfdrc_pkg::PH_HUNT || phase == rfdrc_pkg::PH_CAPTURE) |-> (wait_ticks == 8'd0),
    "tick counter nonzero outside the wait")
  `RFDRC_ASSERT(a_fail_is_last,
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast,
    "failure beat without last flag")
  `RFDRC_ASSERT(a_drop_to_start,
    (in_fire && !s_axis_tuser && phase == rfdrc_pkg::PH_DROP) |=> ##1 (phase == rfdrc_pkg::PH_START),
    "dropped byte did not advance to start check")
  `RFDRC_ASSERT_ALWAYS(a_count_range,
    rst || (count <= LAST_IDX),
    "byte index beyond tag length")

endmodule

// ===== tb/rfid_frame_double_read_check_unit_test.sv =====
module rfid_frame_double_read_check_unit_test;

  localparam int TAG_BYTES = 10;
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  // margin for the last byte's steps and a confirmed read's 10 beats
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx;
  } reader_item_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] tag;
    logic [3:0] pos;
    logic       last;
  } tag_beat_t;

  typedef enum {
    READ_MATCH,
    READ_SHORT,
    READ_MISMATCH,
    READ_NO_START,
    READ_TIMEOUT
  } read_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0;    // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] tag_byte, [11:8] tag_index
  logic        m_axis_tuser;           // [0] tag_ok
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [rfdrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]  cfg_data = 8'h00;

  rfid_frame_double_read_check_unit #(
    .TAG_BYTES(TAG_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Stimulus and expectation stores
  reader_item_t reader_items[$];
  tag_beat_t    tag_beats_due[$];
  int           items_issued = 0;
  int           items_taken = 0;
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic         rx_hold = 1'b0;
  reader_item_t offered;

  // Shadow of the frame checker
  rfdrc_pkg::frame_phase_t ph_state = rfdrc_pkg::PH_HUNT;
  logic [7:0]   tag_copy [TAG_BYTES];
  logic [3:0]   byte_pos = 4'd0;
  logic [7:0]   ticks_waited = 8'd0;
  logic [7:0]   timeout_reg = rfdrc_pkg::TIMEOUT_TICKS_RST;
  logic [7:0]   start_reg = rfdrc_pkg::START_CODE_RST;
  logic [7:0]   stop_reg = rfdrc_pkg::STOP_CODE_RST;

  function automatic void fail_read();
    for (int i = 0; i < TAG_BYTES; i++) tag_copy[i] = 8'h00;
    ph_state = rfdrc_pkg::PH_HUNT;
    byte_pos = 4'd0;
    ticks_waited = 8'd0;
    tag_beats_due.push_back('{ok: 1'b0, tag: 8'h00, pos: 4'd0, last: 1'b1});
  endfunction

  function automatic void confirm_read();
    for (int i = 0; i < TAG_BYTES; i++)
      tag_beats_due.push_back('{ok: 1'b1, tag: tag_copy[i], pos: 4'(i),
                                last: (i == TAG_BYTES - 1)});
    ph_state = rfdrc_pkg::PH_HUNT;
    byte_pos = 4'd0;
    ticks_waited = 8'd0;
  endfunction

  function automatic void await_repeat();
    ticks_waited = 8'd0;
    byte_pos = 4'd0;
    ph_state = rfdrc_pkg::PH_DROP;
  endfunction

  function automatic void track_reader_item(reader_item_t it);
    // ticks only matter while waiting for the confirming frame
    if (it.req_type == REQ_TICK) begin
      if (ph_state == rfdrc_pkg::PH_DROP || ph_state == rfdrc_pkg::PH_START) begin
        if (ticks_waited > timeout_reg || ticks_waited == rfdrc_pkg::WAIT_MAX) fail_read();
        else ticks_waited = ticks_waited + 8'd1;
      end
      return;
    end
    case (ph_state)
      rfdrc_pkg::PH_CAPTURE: begin
        if (it.rx == stop_reg) await_repeat();
        else if (int'(byte_pos) >= TAG_BYTES) await_repeat();
        else begin
          tag_copy[byte_pos] = it.rx;
          if (int'(byte_pos) + 1 >= TAG_BYTES) await_repeat();
          else byte_pos = byte_pos + 4'd1;
        end
      end
      rfdrc_pkg::PH_DROP: ph_state = rfdrc_pkg::PH_START;
      rfdrc_pkg::PH_START: begin
        if (it.rx != start_reg) fail_read();
        else begin
          byte_pos = 4'd0;
          ph_state = rfdrc_pkg::PH_COMPARE;
        end
      end
      rfdrc_pkg::PH_COMPARE: begin
        if (it.rx == stop_reg) confirm_read();
        else if (int'(byte_pos) >= TAG_BYTES) confirm_read();
        else if (tag_copy[byte_pos] != it.rx) fail_read();
        else if (int'(byte_pos) + 1 >= TAG_BYTES) confirm_read();
        else byte_pos = byte_pos + 4'd1;
      end
      default: begin
        ph_state = rfdrc_pkg::PH_HUNT;
        if (it.rx == start_reg) begin
          byte_pos = 4'd0;
          ph_state = rfdrc_pkg::PH_CAPTURE;
        end
      end
    endcase
  endfunction

  // Input driver: one beat per handshake, random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_reader_item(offered);
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (reader_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = reader_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= offered.req_type;
          s_axis_tdata  <= offered.rx;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    tag_beat_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tag_beats_due.size() == 0) begin
          $display("%0t: unexpected beat: expected none, got tdata=%h tuser=%b tlast=%b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = tag_beats_due.pop_front();
          if (m_axis_tuser !== want.ok) begin
            $display("%0t: tag_ok expected %b, got %b", $time, want.ok, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata[7:0] !== want.tag) begin
            $display("%0t: tag_byte expected %h, got %h", $time, want.tag,
                     m_axis_tdata[7:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[11:8] !== want.pos) begin
            $display("%0t: tag_index expected %0d, got %0d", $time, want.pos,
                     m_axis_tdata[11:8]);
            mismatch_count++;
          end
          if (m_axis_tdata[15:12] !== 4'h0) begin
            $display("%0t: tdata padding expected 0, got %h", $time, m_axis_tdata[15:12]);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last_of_run expected %b, got %b", $time, want.last,
                     m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic add_item(input logic req_type, input logic [7:0] rx);
    reader_items.push_back('{req_type: req_type, rx: rx});
    items_issued++;
  endtask

  // occasional tick where it is ignored (capture, compare)
  task automatic maybe_tick();
    if ($urandom_range(9) == 0) add_item(REQ_TICK, 8'($urandom));
  endtask

  task automatic write_reg(input logic [rfdrc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rfdrc_pkg::REG_TIMEOUT_TICKS: timeout_reg = val;
      rfdrc_pkg::REG_START_CODE:    start_reg = val;
      rfdrc_pkg::REG_STOP_CODE:     stop_reg = val;
      default: ;
    endcase
  endtask

  // wait until every item is taken and every result seen, then let the block settle
  task automatic drain_reads();
    while (items_taken != items_issued || tag_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One double read: frame, dropped byte, wait ticks, repeat frame
  task automatic queue_read(input read_kind_t kind, input int len);
    logic [7:0] frame_bytes [TAG_BYTES];
    int n_ticks;
    int n_rep;
    int bad_pos;
    for (int i = 0; i < len; i++) begin
      frame_bytes[i] = 8'($urandom);
      while (frame_bytes[i] == stop_reg) frame_bytes[i] = 8'($urandom);
    end
    add_item(REQ_BYTE, start_reg);
    for (int i = 0; i < len; i++) begin
      maybe_tick();
      add_item(REQ_BYTE, frame_bytes[i]);
    end
    if (len < TAG_BYTES) add_item(REQ_BYTE, stop_reg);
    add_item(REQ_BYTE, 8'($urandom));
    if (kind == READ_TIMEOUT) begin
      n_ticks = (timeout_reg == rfdrc_pkg::WAIT_MAX) ? 256 : int'(timeout_reg) + 2;
      repeat (n_ticks) add_item(REQ_TICK, 8'($urandom));
      return;
    end
    n_ticks = $urandom_range(0, (timeout_reg < 8'd3) ? int'(timeout_reg) : 3);
    repeat (n_ticks) add_item(REQ_TICK, 8'($urandom));
    if (kind == READ_NO_START) begin
      add_item(REQ_BYTE, start_reg ^ 8'($urandom_range(1, 255)));
      return;
    end
    add_item(REQ_BYTE, start_reg);
    bad_pos = (kind == READ_MISMATCH) ? $urandom_range(0, len - 1) : -1;
    n_rep = (kind == READ_SHORT) ? $urandom_range(0, len - 1) :
            (kind == READ_MISMATCH) ? bad_pos + 1 : len;
    for (int i = 0; i < n_rep; i++) begin
      maybe_tick();
      if (i == bad_pos) add_item(REQ_BYTE, frame_bytes[i] ^ 8'($urandom_range(1, 255)));
      else add_item(REQ_BYTE, frame_bytes[i]);
    end
    if (kind == READ_SHORT || (kind == READ_MATCH && len < TAG_BYTES))
      add_item(REQ_BYTE, stop_reg);
  endtask

  task automatic run_random_phase(input int send_pct, input int stall, input int n_items);
    int first;
    int roll;
    int len;
    logic [7:0] code;
    send_idle_pct = send_pct;
    stall_pct = stall;
    write_reg(rfdrc_pkg::REG_TIMEOUT_TICKS, 8'($urandom_range(1, 8)));
    code = 8'($urandom);
    write_reg(rfdrc_pkg::REG_START_CODE, code);
    while (code == start_reg) code = 8'($urandom);
    write_reg(rfdrc_pkg::REG_STOP_CODE, code);
    first = items_issued;
    while (items_issued - first < n_items) begin
      roll = $urandom_range(99);
      len = ($urandom_range(2) == 0) ? $urandom_range(1, TAG_BYTES - 1) : TAG_BYTES;
      if (roll < 45) queue_read(READ_MATCH, len);
      else if (roll < 60) queue_read(READ_SHORT, len);
      else if (roll < 75) queue_read(READ_MISMATCH, len);
      else if (roll < 83) queue_read(READ_NO_START, len);
      else if (roll < 90) queue_read(READ_TIMEOUT, len);
      else repeat ($urandom_range(1, 4)) add_item(1'($urandom), 8'($urandom));
    end
    drain_reads();
  endtask

  // Main sequence
  initial begin
    for (int i = 0; i < TAG_BYTES; i++) tag_copy[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset codes: ignored tick and bytes while hunting, short frame confirmed
    add_item(REQ_TICK, 8'hFF);
    add_item(REQ_BYTE, 8'hFF);
    add_item(REQ_BYTE, 8'h00);
    add_item(REQ_BYTE, rfdrc_pkg::START_CODE_RST);
    add_item(REQ_BYTE, 8'h00);
    add_item(REQ_TICK, 8'h00);
    add_item(REQ_BYTE, 8'hFF);
    add_item(REQ_BYTE, 8'h5A);
    add_item(REQ_BYTE, rfdrc_pkg::STOP_CODE_RST);
    add_item(REQ_TICK, 8'hA5);
    add_item(REQ_BYTE, rfdrc_pkg::START_CODE_RST);   // dropped whatever its value
    add_item(REQ_BYTE, rfdrc_pkg::START_CODE_RST);
    add_item(REQ_BYTE, 8'h00);
    add_item(REQ_TICK, 8'h00);
    add_item(REQ_BYTE, 8'hFF);
    add_item(REQ_BYTE, 8'h5A);
    add_item(REQ_BYTE, rfdrc_pkg::STOP_CODE_RST);
    // confirming frame without its start byte
    add_item(REQ_BYTE, rfdrc_pkg::START_CODE_RST);
    add_item(REQ_BYTE, 8'h11);
    add_item(REQ_BYTE, rfdrc_pkg::STOP_CODE_RST);
    add_item(REQ_BYTE, 8'h00);
    add_item(REQ_BYTE, 8'h22);
    drain_reads();

    // timeout of one tick: third tick fails the read
    write_reg(rfdrc_pkg::REG_TIMEOUT_TICKS, 8'd1);
    add_item(REQ_BYTE, rfdrc_pkg::START_CODE_RST);
    add_item(REQ_BYTE, 8'h33);
    add_item(REQ_BYTE, rfdrc_pkg::STOP_CODE_RST);
    add_item(REQ_BYTE, 8'h44);
    repeat (3) add_item(REQ_TICK, 8'h00);
    drain_reads();

    // extreme codes, full-length frame
    write_reg(rfdrc_pkg::REG_START_CODE, 8'h00);
    write_reg(rfdrc_pkg::REG_STOP_CODE, 8'hFF);
    queue_read(READ_MATCH, TAG_BYTES);
    drain_reads();

    // longest timeout setting, short frame
    write_reg(rfdrc_pkg::REG_START_CODE, 8'hFF);
    write_reg(rfdrc_pkg::REG_STOP_CODE, 8'h00);
    write_reg(rfdrc_pkg::REG_TIMEOUT_TICKS, 8'hFF);
    queue_read(READ_MATCH, 2);
    drain_reads();

    // receiver held off while confirmed reads pile up
    write_reg(rfdrc_pkg::REG_TIMEOUT_TICKS, 8'd4);
    rx_hold <= 1'b1;
    repeat (2) queue_read(READ_MATCH, 1);
    fork
      begin
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    drain_reads();

    run_random_phase(0, 0, 5);
    run_random_phase(53, 0, 5);
    run_random_phase(0, 53, 5);
    run_random_phase(19, 19, 5);

    if (mismatch_count == 0) begin
      $display("rfid_frame_double_read_check_unit test passed");
    end else begin
      $display("rfid_frame_double_read_check_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("rfid_frame_double_read_check_unit test failed");
    $finish;
  end

endmodule
